>>> sv/assert_macros.svh
// Assertion helpers, clocked and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> sv/btbb_pkg.sv
`default_nettype none

package btbb_pkg;

    localparam int MAX_DIM  = 4096;
    localparam int COORD_W  = 12;
    localparam int DIM_W    = 13;
    localparam int CHAN_W   = 8;

    localparam logic [DIM_W-1:0]  RESET_FRAME_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]  RESET_FRAME_HEIGHT = 13'd480;
    localparam logic [CHAN_W-1:0] RESET_TOLERANCE    = 8'd0;

    typedef enum logic [1:0] {
        ST_ALL_BORDER = 2'd0,
        ST_NO_BORDER  = 2'd1,
        ST_CROP       = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_TOLERANCE    = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_pixel;

    typedef struct packed {
        logic [CHAN_W-1:0] tolerance;
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
    } t_cfg;

    // Last valid index of a dimension: 0 acts as 1, oversize clamps to MAX_DIM
    function automatic logic [COORD_W-1:0] last_index(input logic [DIM_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v == '0) begin
            r = '0;
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = COORD_W'(MAX_DIM - 1);
        end else begin
            r = COORD_W'(v - DIM_W'(1));
        end
        return r;
    endfunction

    function automatic logic chan_far(input logic [CHAN_W-1:0] a,
                                      input logic [CHAN_W-1:0] b,
                                      input logic [CHAN_W-1:0] tol);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d > tol;
    endfunction

endpackage

`default_nettype wire

>>> sv/btbb_in_reg.sv
`default_nettype none

module btbb_in_reg
    import btbb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_in_valid,
    output logic        o_in_stall,
    input  wire t_pixel i_pixel,
    input  wire logic   i_take,
    output logic        o_valid,
    output t_pixel      o_pixel
);

    logic   r_valid;
    t_pixel r_pixel;

    assign o_in_stall = r_valid && !i_take;
    assign o_valid    = r_valid;
    assign o_pixel    = r_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_pixel <= i_pixel;
        end
    end

endmodule

`default_nettype wire

>>> sv/btbb_tracker.sv
`default_nettype none

module btbb_tracker
    import btbb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_valid,
    input  wire t_pixel             i_pixel,
    output logic                    o_take,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_status                 o_status,
    output logic [COORD_W-1:0]      o_left,
    output logic [COORD_W-1:0]      o_top,
    output logic [DIM_W-1:0]        o_crop_width,
    output logic [DIM_W-1:0]        o_crop_height
);

    logic [COORD_W-1:0] r_col, r_row, r_minc, r_maxc, r_minr, r_maxr;
    logic [COORD_W-1:0] n_col, n_row, n_minc, n_maxc, n_minr, n_maxr;
    logic               r_seen, n_seen;
    t_pixel             r_border, n_border;
    logic               r_out_valid, n_out_valid;
    t_status            r_status, n_status;
    logic [COORD_W-1:0] r_left, n_left, r_top, n_top;
    logic [DIM_W-1:0]   r_cw, n_cw, r_ch, n_ch;

    logic [COORD_W-1:0] w_last, h_last, bminc, bmaxc, bminr, bmaxr;
    logic               first, content, row_end, frame_end, adv, bseen;

    assign o_take = !r_out_valid || !i_out_stall;
    assign adv    = i_valid && o_take;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_left        = r_left;
    assign o_top         = r_top;
    assign o_crop_width  = r_cw;
    assign o_crop_height = r_ch;

    always_comb begin
        w_last = last_index(i_cfg.frame_width);
        h_last = last_index(i_cfg.frame_height);
        first  = (r_col == '0) && (r_row == '0);
        // first pixel is its own border colour, never content
        content = !first && (
            chan_far(i_pixel.red,   r_border.red,   i_cfg.tolerance) ||
            chan_far(i_pixel.green, r_border.green, i_cfg.tolerance) ||
            chan_far(i_pixel.blue,  r_border.blue,  i_cfg.tolerance) ||
            chan_far(i_pixel.alpha, r_border.alpha, i_cfg.tolerance));

        bseen = r_seen || content;
        bminc = r_minc;
        bmaxc = r_maxc;
        bminr = r_minr;
        bmaxr = r_maxr;
        if (content && !r_seen) begin
            bminc = r_col;
            bmaxc = r_col;
            bminr = r_row;
            bmaxr = r_row;
        end else if (content) begin
            if (r_col < r_minc) bminc = r_col;
            if (r_col > r_maxc) bmaxc = r_col;
            if (r_row < r_minr) bminr = r_row;
            if (r_row > r_maxr) bmaxr = r_row;
        end

        row_end   = r_col >= w_last;
        frame_end = row_end && (r_row >= h_last);

        n_border = first ? i_pixel : r_border;
        n_col    = row_end ? '0 : r_col + COORD_W'(1);
        n_row    = frame_end ? '0 : (row_end ? r_row + COORD_W'(1) : r_row);
        n_seen   = frame_end ? 1'b0 : bseen;
        n_minc   = frame_end ? '0 : bminc;
        n_maxc   = frame_end ? '0 : bmaxc;
        n_minr   = frame_end ? '0 : bminr;
        n_maxr   = frame_end ? '0 : bmaxr;

        n_left = '0;
        n_top  = '0;
        n_cw   = {1'b0, w_last} + DIM_W'(1);
        n_ch   = {1'b0, h_last} + DIM_W'(1);
        if (!bseen) begin
            n_status = ST_ALL_BORDER;
        end else if (bminc == '0 && bminr == '0 && bmaxc == w_last && bmaxr == h_last) begin
            n_status = ST_NO_BORDER;
        end else begin
            n_status = ST_CROP;
            n_left   = bminc;
            n_top    = bminr;
            n_cw     = {1'b0, bmaxc} - {1'b0, bminc} + DIM_W'(1);
            n_ch     = {1'b0, bmaxr} - {1'b0, bminr} + DIM_W'(1);
        end

        n_out_valid = o_take ? (adv && frame_end) : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_seen      <= 1'b0;
            r_minc      <= '0;
            r_maxc      <= '0;
            r_minr      <= '0;
            r_maxr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (adv) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_seen <= n_seen;
                r_minc <= n_minc;
                r_maxc <= n_maxc;
                r_minr <= n_minr;
                r_maxr <= n_maxr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_border <= n_border;
        end
        if (adv && frame_end) begin
            r_status <= n_status;
            r_left   <= n_left;
            r_top    <= n_top;
            r_cw     <= n_cw;
            r_ch     <= n_ch;
        end
    end

endmodule

`default_nettype wire

>>> sv/border_trim_bounding_box.sv
// Border trim bounding box: takes one pixel per clock in raster order and,
// on the last pixel of each frame (from the configured width and height),
// gives one result: all border colour, no uniform border, or the crop
// rectangle of the content. Sustained rate is one pixel per cycle unless
// the output stalls; a pixel passes an input register and the box update
// into the result register, loaded as a frame's last pixel is taken. Input
// stall rises only while a result is held by a stalled output. The
// configuration port is always ready; write it only between frames.
`default_nettype none

module border_trim_bounding_box
    import btbb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [DIM_W-1:0]   i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [CHAN_W-1:0]  i_red,
    input  wire logic [CHAN_W-1:0]  i_green,
    input  wire logic [CHAN_W-1:0]  i_blue,
    input  wire logic [CHAN_W-1:0]  i_alpha,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_status,
    output logic [COORD_W-1:0]      o_left,
    output logic [COORD_W-1:0]      o_top,
    output logic [DIM_W-1:0]        o_crop_width,
    output logic [DIM_W-1:0]        o_crop_height
);

    `include "assert_macros.svh"

    t_cfg    r_cfg;
    t_pixel  in_pixel, st_pixel;
    logic    st_valid, take;
    t_status status;

    assign o_cfg_ready = 1'b1;
    assign in_pixel    = '{red: i_red, green: i_green, blue: i_blue, alpha: i_alpha};
    assign o_status    = status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tolerance    <= RESET_TOLERANCE;
            r_cfg.frame_width  <= RESET_FRAME_WIDTH;
            r_cfg.frame_height <= RESET_FRAME_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TOLERANCE:    r_cfg.tolerance    <= i_cfg_data[CHAN_W-1:0];
                CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    btbb_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_pixel    (in_pixel),
        .i_take     (take),
        .o_valid    (st_valid),
        .o_pixel    (st_pixel)
    );

    btbb_tracker u_tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (st_valid),
        .i_pixel       (st_pixel),
        .o_take        (take),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (status),
        .o_left        (o_left),
        .o_top         (o_top),
        .o_crop_width  (o_crop_width),
        .o_crop_height (o_crop_height)
    );

    `ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    `ASSERT_SAME(a_origin_no_crop, i_clk, i_rst_n, o_out_valid && (o_status != ST_CROP), o_left == '0 && o_top == '0)
    `ASSERT_SAME(a_crop_fits, i_clk, i_rst_n, o_out_valid && (o_status == ST_CROP), (o_crop_width != '0) && (o_crop_height != '0) && (14'(o_left) + 14'(o_crop_width) <= 14'(MAX_DIM)))
    `ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_crop_width))

endmodule

`default_nettype wire
